@@ hw/rtl/wmm_pkg.sv @@
`timescale 1ns / 1ps

package wmm_pkg;

  localparam int SAMPLE_W = 10;
  localparam int MED_W    = 11;
  localparam int CNT_W    = 8;

  localparam logic [CNT_W-1:0] INTERVAL_RESET = 8'd10;
  localparam logic [CNT_W-1:0] CNT_MAX        = 8'd255;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [MED_W-1:0]    median_t;
  typedef logic [CNT_W-1:0]    count_t;

  // scan control from the sequencer to every lane
  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctrl_t;

  // what one lane found over its window
  typedef struct packed {
    sample_t min_val;
    sample_t max_val;
    median_t med_half;
  } lane_stats_t;

endpackage

@@ hw/rtl/wmm_if.sv @@
`timescale 1ns / 1ps

interface wmm_sample_if;
  logic             valid;
  logic             ready;
  wmm_pkg::sample_t temp_sample;
  wmm_pkg::sample_t humidity_sample;
  wmm_pkg::sample_t gas_sample;

  modport source (output valid, output temp_sample, output humidity_sample,
                  output gas_sample, input ready);
  modport sink   (input valid, input temp_sample, input humidity_sample,
                  input gas_sample, output ready);
endinterface

interface wmm_report_if;
  logic             valid;
  logic             ready;
  wmm_pkg::sample_t temp_min;
  wmm_pkg::sample_t temp_max;
  wmm_pkg::median_t temp_median_half;
  wmm_pkg::sample_t hum_min;
  wmm_pkg::sample_t hum_max;
  wmm_pkg::median_t hum_median_half;
  wmm_pkg::sample_t gas_min;
  wmm_pkg::sample_t gas_max;
  wmm_pkg::median_t gas_median_half;

  modport source (output valid, output temp_min, output temp_max,
                  output temp_median_half, output hum_min, output hum_max,
                  output hum_median_half, output gas_min, output gas_max,
                  output gas_median_half, input ready);
  modport sink   (input valid, input temp_min, input temp_max,
                  input temp_median_half, input hum_min, input hum_max,
                  input hum_median_half, input gas_min, input gas_max,
                  input gas_median_half, output ready);
endinterface

interface wmm_cfg_if;
  logic            valid;
  logic            ready;
  wmm_pkg::count_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/window_min_max_median_reporter.sv @@
`timescale 1ns / 1ps

// channel   dir  modport  carries
// sample    in   sink     temp_sample, humidity_sample, gas_sample
// report    out  source   min, max and median_half of each sensor window
// cfg       in   sink     report_interval write data, always ready
//
// a sample that raises no report is only written; one that raises a report
// is written, then every window entry is rank-scanned in turn
// (one candidate compared against the whole window in each lane), then the
// results are loaded into the report register
// the report register parts the two sides; samples keep flowing while it is
// full unless the next sample would raise another report
// rst is synchronous, active high: windows, slot and counter go to zero,
// report_interval to 10

module window_min_max_median_reporter #(
  parameter int WINDOW = 3
) (
  input  logic          clk,
  input  logic          rst,
  wmm_sample_if.sink    sample,
  wmm_report_if.source  report,
  wmm_cfg_if.sink       cfg
);

  localparam int SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [SW-1:0] LAST_SLOT = SW'(WINDOW - 1);

  // sequencer codes
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]           state;
  logic [1:0]           state_next;
  logic [SW-1:0]        scan_idx;
  logic [SW-1:0]        write_slot;
  wmm_pkg::count_t      interval;
  wmm_pkg::count_t      cnt;
  wmm_pkg::count_t      cnt_inc;
  logic                 due;
  logic                 accept;
  logic                 scan_last;
  wmm_pkg::scan_ctrl_t  ctrl;
  wmm_pkg::lane_stats_t temp_stats;
  wmm_pkg::lane_stats_t hum_stats;
  wmm_pkg::lane_stats_t gas_stats;

  // saturating sample count, and whether this transfer raises a report
  assign cnt_inc = (cnt == wmm_pkg::CNT_MAX) ? cnt : cnt + 8'd1;
  assign due     = (cnt_inc >= interval);

  // hold samples off only while scanning or loading the report, or when a
  // report is due and the previous one has not been taken yet
  assign sample.ready = (state == ST_IDLE) && (!report.valid || !due);
  assign accept       = sample.valid && sample.ready;
  assign scan_last    = (scan_idx == LAST_SLOT);

  assign ctrl.clear = accept && due;
  assign ctrl.step  = (state == ST_SCAN);

  // configuration register, writes taken at any time
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= wmm_pkg::INTERVAL_RESET;
    end else if (cfg.valid) begin
      interval <= cfg.data;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && due) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      scan_idx   <= '0;
      write_slot <= '0;
      cnt        <= '0;
    end else begin
      state <= state_next;
      if (state == ST_SCAN) begin
        scan_idx <= scan_last ? '0 : scan_idx + SW'(1);
      end
      if (accept) begin
        write_slot <= (write_slot == LAST_SLOT) ? '0 : write_slot + SW'(1);
        cnt        <= due ? '0 : cnt_inc;
      end
    end
  end

  // one lane per sensor, all written at the same slot and scanned together
  wmm_lane #(.WINDOW(WINDOW)) u_temp_lane (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept),
    .wr_slot  (write_slot),
    .wr_data  (sample.temp_sample),
    .ctrl     (ctrl),
    .scan_idx (scan_idx),
    .stats    (temp_stats)
  );

  wmm_lane #(.WINDOW(WINDOW)) u_hum_lane (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept),
    .wr_slot  (write_slot),
    .wr_data  (sample.humidity_sample),
    .ctrl     (ctrl),
    .scan_idx (scan_idx),
    .stats    (hum_stats)
  );

  wmm_lane #(.WINDOW(WINDOW)) u_gas_lane (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept),
    .wr_slot  (write_slot),
    .wr_data  (sample.gas_sample),
    .ctrl     (ctrl),
    .scan_idx (scan_idx),
    .stats    (gas_stats)
  );

  // gathers the three lanes into the report register
  wmm_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .load       (state == ST_FINISH),
    .temp_stats (temp_stats),
    .hum_stats  (hum_stats),
    .gas_stats  (gas_stats),
    .rpt        (report)
  );

`ifndef SYNTH
  // a report only appears after a full scan
  a_report_after_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(report.valid) |-> ($past(state) == ST_FINISH))
    else $error("report raised without a finished scan");

  // a transfer that raises a report clears the count and starts the scan
  a_due_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (accept && due) |=> ((cnt == '0) && (state == ST_SCAN) && (scan_idx == '0)))
    else $error("due report did not start a scan");

  // the report register is never overwritten while it still holds a report
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |-> !report.valid)
    else $error("report register loaded while full");
`endif

endmodule

@@ hw/rtl/wmm_lane.sv @@
`timescale 1ns / 1ps

module wmm_lane #(
  parameter int WINDOW = 3,
  parameter int SW     = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [SW-1:0]        wr_slot,
  input  wmm_pkg::sample_t     wr_data,
  input  wmm_pkg::scan_ctrl_t  ctrl,
  input  logic [SW-1:0]        scan_idx,
  output wmm_pkg::lane_stats_t stats
);

  localparam logic [SW-1:0] RANK_MIN = '0;
  localparam logic [SW-1:0] RANK_MAX = SW'(WINDOW - 1);
  localparam logic [SW-1:0] MID_LO   = SW'((WINDOW - 1) / 2);
  localparam logic [SW-1:0] MID_HI   = SW'(WINDOW / 2);

  wmm_pkg::sample_t win [WINDOW];
  wmm_pkg::sample_t cand;
  logic [SW-1:0]    rank;
  wmm_pkg::sample_t min_val;
  wmm_pkg::sample_t max_val;
  wmm_pkg::median_t med_acc;
  wmm_pkg::median_t med_add_lo;
  wmm_pkg::median_t med_add_hi;

  // rank of the candidate: smaller entries plus equal ones at lower slots
  always_comb begin
    cand = win[scan_idx];
    rank = '0;
    for (int j = 0; j < WINDOW; j++) begin
      if ((win[j] < cand) || ((win[j] == cand) && (SW'(j) < scan_idx))) begin
        rank = rank + SW'(1);
      end
    end
    med_add_lo = (rank == MID_LO) ? wmm_pkg::median_t'(cand) : '0;
    med_add_hi = (rank == MID_HI) ? wmm_pkg::median_t'(cand) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < WINDOW; j++) begin
        win[j] <= '0;
      end
    end else if (wr_en) begin
      win[wr_slot] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      med_acc <= '0;
    end else if (ctrl.step) begin
      if (rank == RANK_MIN) begin
        min_val <= cand;
      end
      if (rank == RANK_MAX) begin
        max_val <= cand;
      end
      // odd window: the middle entry matches both and is added twice
      med_acc <= med_acc + med_add_lo + med_add_hi;
    end
  end

  assign stats.min_val  = min_val;
  assign stats.max_val  = max_val;
  assign stats.med_half = med_acc;

endmodule

@@ hw/rtl/wmm_merge.sv @@
`timescale 1ns / 1ps

module wmm_merge (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  wmm_pkg::lane_stats_t temp_stats,
  input  wmm_pkg::lane_stats_t hum_stats,
  input  wmm_pkg::lane_stats_t gas_stats,
  wmm_report_if.source         rpt
);

  always_ff @(posedge clk) begin
    if (rst) begin
      rpt.valid <= 1'b0;
    end else if (load) begin
      rpt.valid <= 1'b1;
    end else if (rpt.ready) begin
      rpt.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rpt.temp_min         <= temp_stats.min_val;
      rpt.temp_max         <= temp_stats.max_val;
      rpt.temp_median_half <= temp_stats.med_half;
      rpt.hum_min          <= hum_stats.min_val;
      rpt.hum_max          <= hum_stats.max_val;
      rpt.hum_median_half  <= hum_stats.med_half;
      rpt.gas_min          <= gas_stats.min_val;
      rpt.gas_max          <= gas_stats.max_val;
      rpt.gas_median_half  <= gas_stats.med_half;
    end
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int          WIN_LEN      = 3;
  // time for a reporting sample's scan and report load to finish, plus some margin
  localparam int          DRAIN_CYCLES = WIN_LEN + 12;
  localparam int unsigned CYCLE_LIMIT  = 100000;
  localparam int          HOLD_CYCLES  = 150;

  // one reading from each of the three sensors
  typedef struct packed {
    wmm_pkg::sample_t temp;
    wmm_pkg::sample_t hum;
    wmm_pkg::sample_t gas;
  } reading_t;

  // one report: min, max and doubled median per sensor window
  typedef struct packed {
    wmm_pkg::lane_stats_t temp;
    wmm_pkg::lane_stats_t hum;
    wmm_pkg::lane_stats_t gas;
  } sensor_report_t;

  logic clk;
  logic rst;

  wmm_sample_if sample_ch ();
  wmm_report_if report_ch ();
  wmm_cfg_if    cfg_ch ();

  window_min_max_median_reporter #(
    .WINDOW(WIN_LEN)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .report (report_ch),
    .cfg    (cfg_ch)
  );

  // readings waiting for the sample driver, reports still owed by the block
  reading_t       pending_readings[$];
  sensor_report_t owed_reports[$];

  // shadow copy of the block's state, advanced on every accepted transfer
  wmm_pkg::sample_t temp_win [WIN_LEN];
  wmm_pkg::sample_t hum_win  [WIN_LEN];
  wmm_pkg::sample_t gas_win  [WIN_LEN];
  int unsigned      next_slot;
  wmm_pkg::count_t  since_report;
  wmm_pkg::count_t  interval_now;

  int unsigned readings_queued;
  int unsigned readings_taken;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  bit          reading_moved;

  // idling controls, set per phase by the stimulus
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  bit          hold_request;
  bit          hold_started;
  int unsigned hold_left;

  wmm_pkg::sample_t last_temp, last_hum, last_gas;

  always #5 clk = ~clk;

  // min, max and doubled median of one window; even windows add the two middle values
  function automatic wmm_pkg::lane_stats_t window_summary(
    input wmm_pkg::sample_t w [WIN_LEN]);
    wmm_pkg::sample_t     ranked [WIN_LEN];
    wmm_pkg::sample_t     key;
    int                   j;
    wmm_pkg::lane_stats_t s;
    s.min_val = w[0];
    s.max_val = w[0];
    for (int i = 0; i < WIN_LEN; i++) begin
      ranked[i] = w[i];
      if (w[i] < s.min_val) s.min_val = w[i];
      if (w[i] > s.max_val) s.max_val = w[i];
    end
    // insertion sort, ascending
    for (int i = 1; i < WIN_LEN; i++) begin
      key = ranked[i];
      j = i;
      while (j > 0 && ranked[j-1] > key) begin
        ranked[j] = ranked[j-1];
        j--;
      end
      ranked[j] = key;
    end
    if (WIN_LEN % 2 == 0)
      s.med_half = wmm_pkg::median_t'(ranked[WIN_LEN/2-1]) +
                   wmm_pkg::median_t'(ranked[WIN_LEN/2]);
    else
      s.med_half = wmm_pkg::median_t'(ranked[WIN_LEN/2]) << 1;
    return s;
  endfunction

  // write the reading into the windows, bump the count, queue a report when due
  task automatic take_reading(input reading_t r);
    sensor_report_t rpt;
    temp_win[next_slot] = r.temp;
    hum_win[next_slot]  = r.hum;
    gas_win[next_slot]  = r.gas;
    next_slot = (next_slot + 1 >= WIN_LEN) ? 0 : next_slot + 1;
    // saturates at the top, never reached in practice
    if (since_report < wmm_pkg::CNT_MAX) since_report++;
    if (since_report >= interval_now) begin
      rpt.temp = window_summary(temp_win);
      rpt.hum  = window_summary(hum_win);
      rpt.gas  = window_summary(gas_win);
      owed_reports.push_back(rpt);
      since_report = '0;
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // prediction and checking, both at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WIN_LEN; i++) begin
        temp_win[i] = '0;
        hum_win[i]  = '0;
        gas_win[i]  = '0;
      end
      next_slot     = 0;
      since_report  = '0;
      interval_now  = wmm_pkg::INTERVAL_RESET;
      reading_moved = 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) interval_now = cfg_ch.data;

      // a report out now can only belong to a reading taken earlier
      if (report_ch.valid && report_ch.ready) begin
        if (owed_reports.size() == 0) begin
          $error("report transfer with nothing owed");
          mismatch_count++;
        end else begin
          check_field("temp_min", 32'(owed_reports[0].temp.min_val),
                      32'(report_ch.temp_min));
          check_field("temp_max", 32'(owed_reports[0].temp.max_val),
                      32'(report_ch.temp_max));
          check_field("temp_median_half", 32'(owed_reports[0].temp.med_half),
                      32'(report_ch.temp_median_half));
          check_field("hum_min", 32'(owed_reports[0].hum.min_val),
                      32'(report_ch.hum_min));
          check_field("hum_max", 32'(owed_reports[0].hum.max_val),
                      32'(report_ch.hum_max));
          check_field("hum_median_half", 32'(owed_reports[0].hum.med_half),
                      32'(report_ch.hum_median_half));
          check_field("gas_min", 32'(owed_reports[0].gas.min_val),
                      32'(report_ch.gas_min));
          check_field("gas_max", 32'(owed_reports[0].gas.max_val),
                      32'(report_ch.gas_max));
          check_field("gas_median_half", 32'(owed_reports[0].gas.med_half),
                      32'(report_ch.gas_median_half));
          void'(owed_reports.pop_front());
        end
      end

      reading_moved = sample_ch.valid && sample_ch.ready;
      if (reading_moved) begin
        take_reading('{temp: sample_ch.temp_sample, hum: sample_ch.humidity_sample,
                       gas: sample_ch.gas_sample});
        readings_taken++;
      end
    end
  end

  // sample driver: holds an item until its transfer, then maybe idles
  always @(negedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
    end else if (!sample_ch.valid || reading_moved) begin
      if (pending_readings.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        sample_ch.valid           <= 1'b1;
        sample_ch.temp_sample     <= pending_readings[0].temp;
        sample_ch.humidity_sample <= pending_readings[0].hum;
        sample_ch.gas_sample      <= pending_readings[0].gas;
        void'(pending_readings.pop_front());
      end else begin
        sample_ch.valid <= 1'b0;
      end
    end
  end

  // report receiver: random stalls, plus one long hold-off counted down here
  always @(negedge clk) begin
    if (rst) begin
      report_ch.ready <= 1'b0;
    end else begin
      if (hold_request && !hold_started) begin
        hold_started = 1'b1;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        report_ch.ready <= 1'b0;
      end else begin
        report_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic push_reading(input int unsigned t, input int unsigned h,
                              input int unsigned g);
    pending_readings.push_back('{temp: wmm_pkg::sample_t'(t), hum: wmm_pkg::sample_t'(h),
                                 gas: wmm_pkg::sample_t'(g)});
    readings_queued++;
  endtask

  // mostly uniform, with a share of extremes and repeats so ties turn up
  function automatic wmm_pkg::sample_t pick_sample(input wmm_pkg::sample_t prev);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return prev;
      default: return wmm_pkg::sample_t'($urandom_range(0, 1023));
    endcase
  endfunction

  // every reading taken and every report back, then let the pipeline settle
  task automatic wait_idle();
    do @(negedge clk);
    while (!(readings_taken == readings_queued && owed_reports.size() == 0));
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // one transfer on the register channel, only called while idle
  task automatic write_interval(input wmm_pkg::count_t value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk);
    while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_phase(input wmm_pkg::count_t interval, input int unsigned n_items,
                              input int unsigned idle_pct, input int unsigned stall_pct);
    write_interval(interval);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int i = 0; i < n_items; i++) begin
      last_temp = pick_sample(last_temp);
      last_hum  = pick_sample(last_hum);
      last_gas  = pick_sample(last_gas);
      push_reading(last_temp, last_hum, last_gas);
    end
    wait_idle();
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    sample_ch.valid           = 1'b0;
    sample_ch.temp_sample     = '0;
    sample_ch.humidity_sample = '0;
    sample_ch.gas_sample      = '0;
    report_ch.ready           = 1'b0;
    cfg_ch.valid              = 1'b0;
    cfg_ch.data               = '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_request       = 1'b0;
    hold_started       = 1'b0;
    hold_left          = 0;
    readings_queued    = 0;
    readings_taken     = 0;
    mismatch_count     = 0;
    cycle_count        = 0;
    last_temp = '0;
    last_hum  = '0;
    last_gas  = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // power-on interval of ten: extremes and walking bits, one report on the tenth
    push_reading(1023, 1023, 1023);
    push_reading(0, 0, 0);
    push_reading(1023, 0, 512);
    push_reading(1, 2, 4);
    push_reading(8, 16, 32);
    push_reading(64, 128, 256);
    push_reading(512, 1, 2);
    push_reading(682, 341, 682);
    push_reading(341, 682, 341);
    push_reading(1023, 1023, 0);
    // five more leave the count part way up
    push_reading(0, 1023, 1023);
    push_reading(1023, 0, 1023);
    push_reading(5, 5, 5);
    push_reading(6, 6, 6);
    push_reading(7, 7, 7);
    wait_idle();

    // interval lowered below the running count: the very next sample reports
    write_interval(8'd2);
    push_reading(1000, 3, 500);
    wait_idle();

    // lowest legal interval, every sample reports; duplicates test ties
    write_interval(8'd1);
    push_reading(1023, 0, 1023);
    push_reading(0, 1023, 0);
    push_reading(1023, 1023, 1023);
    push_reading(1023, 1023, 1023);
    wait_idle();

    // interval of zero behaves as every sample
    write_interval(8'd0);
    push_reading(0, 0, 0);
    push_reading(512, 511, 1023);
    push_reading(511, 512, 0);
    wait_idle();

    // random phases under each idling pattern
    random_phase(8'd1, 30, 0, 0);
    random_phase(8'd3, 30, 53, 0);
    random_phase(8'd2, 30, 0, 53);
    random_phase(wmm_pkg::count_t'($urandom_range(2, 9)), 30, 8, 8);

    // receiver holds off while the sender keeps pushing, so the block backs up
    hold_request = 1'b1;
    random_phase(8'd1, 30, 0, 0);

    // top interval: one report after exactly 255 samples from a zero count
    random_phase(8'd255, 255, 8, 8);

    // a final short burst at the reset value
    random_phase(wmm_pkg::INTERVAL_RESET, 20, 0, 0);

    if (mismatch_count == 0 && owed_reports.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

@@ window_min_max_median_reporter.f @@
hw/rtl/wmm_pkg.sv
hw/rtl/wmm_if.sv
hw/rtl/wmm_lane.sv
hw/rtl/wmm_merge.sv
hw/rtl/window_min_max_median_reporter.sv
bench/testbench.sv
